// ----- sv/spgd_pkg.sv -----
package spgd_pkg;

    localparam int NUM_BINS   = 4096;

    localparam int MAG_W      = 16;
    localparam int BIN_W      = 12;
    localparam int GAP_W      = 6;
    localparam int CNT_W      = 13;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_BIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT = 2'd2;

    localparam logic [MAG_W-1:0] THRESHOLD_RST = 16'd32768;
    localparam logic [BIN_W-1:0] START_BIN_RST = 12'd0;
    localparam logic [GAP_W-1:0] GAP_LIMIT_RST = 6'd12;

    localparam logic [PHASE_W-1:0] PH_SEARCH = 2'd0;
    localparam logic [PHASE_W-1:0] PH_GROUP  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SKIP   = 2'd2;

    localparam int   BIN_SPAN      = 2 ** BIN_W;
    localparam logic LAST_BIN_FITS = ((NUM_BINS - 1) < BIN_SPAN);
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'((NUM_BINS - 1) % BIN_SPAN);
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    typedef struct packed {
        logic [MAG_W-1:0] threshold;
        logic [BIN_W-1:0] start_bin;
        logic [GAP_W-1:0] gap_limit;
    } t_cfg;

    typedef struct packed {
        logic             group_valid;
        logic [BIN_W-1:0] first_bin;
        logic [BIN_W-1:0] last_bin;
        logic [BIN_W-1:0] peak_bin;
        logic [MAG_W-1:0] peak_mag;
        logic [CNT_W-1:0] group_index;
        logic             frame_end;
    } t_result;

endpackage

// ----- sv/spgd_bin_if.sv -----
interface spgd_bin_if;
    import spgd_pkg::*;

    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] bin_mag;
    logic             frame_last;

    modport source (output valid, output bin_mag, output frame_last, input ready);
    modport sink   (input valid, input bin_mag, input frame_last, output ready);
endinterface

// ----- sv/spgd_grp_if.sv -----
interface spgd_grp_if;
    import spgd_pkg::*;

    logic             valid;
    logic             ready;
    logic             group_valid;
    logic [BIN_W-1:0] first_bin;
    logic [BIN_W-1:0] last_bin;
    logic [BIN_W-1:0] peak_bin;
    logic [MAG_W-1:0] peak_mag;
    logic [CNT_W-1:0] group_index;
    logic             frame_end;

    modport source (
        output valid, output group_valid, output first_bin, output last_bin,
        output peak_bin, output peak_mag, output group_index, output frame_end,
        input ready
    );
    modport sink (
        input valid, input group_valid, input first_bin, input last_bin,
        input peak_bin, input peak_mag, input group_index, input frame_end,
        output ready
    );
endinterface

// ----- sv/spgd_cfg_if.sv -----
interface spgd_cfg_if;
    import spgd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/spgd_cfg_regs.sv -----
module spgd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    spgd_cfg_if.sink                       i_cfg,
    output spgd_pkg::t_cfg                 o_cfg
);
    import spgd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_THRESHOLD: n_cfg.threshold = i_cfg.data[MAG_W-1:0];
                REG_START_BIN: n_cfg.start_bin = i_cfg.data[BIN_W-1:0];
                REG_GAP_LIMIT: n_cfg.gap_limit = i_cfg.data[GAP_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RST;
            r_cfg.start_bin <= START_BIN_RST;
            r_cfg.gap_limit <= GAP_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- sv/spgd_scan.sv -----
module spgd_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spgd_pkg::t_cfg             i_cfg,
    input  logic                       i_fire,
    input  logic [spgd_pkg::MAG_W-1:0] i_mag,
    input  logic                       i_last,
    output logic                       o_res_valid,
    output spgd_pkg::t_result          o_res
);
    import spgd_pkg::*;

    logic [BIN_W-1:0]   r_bin_counter, n_bin_counter;
    logic [PHASE_W-1:0] r_phase,       n_phase;
    logic [BIN_W-1:0]   r_first,       n_first;
    logic [BIN_W-1:0]   r_last_hit,    n_last_hit;
    logic [GAP_W-1:0]   r_gap,         n_gap;
    logic [BIN_W-1:0]   r_best_bin,    n_best_bin;
    logic [MAG_W-1:0]   r_best_mag,    n_best_mag;
    logic [CNT_W-1:0]   r_groups,      n_groups;

    logic             end_bin;
    logic             hit;
    logic             closed;
    logic [GAP_W-1:0] gap_lim;
    logic [GAP_W-1:0] gap_inc;

    assign end_bin = i_last || (LAST_BIN_FITS && (r_bin_counter == LAST_BIN));
    assign hit     = i_mag > i_cfg.threshold;
    assign gap_lim = (i_cfg.gap_limit == '0) ? GAP_W'(1) : i_cfg.gap_limit;
    assign gap_inc = r_gap + GAP_W'(1);

    always_comb begin
        n_bin_counter = r_bin_counter;
        n_phase       = r_phase;
        n_first       = r_first;
        n_last_hit    = r_last_hit;
        n_gap         = r_gap;
        n_best_bin    = r_best_bin;
        n_best_mag    = r_best_mag;
        n_groups      = r_groups;
        closed        = 1'b0;

        unique case (r_phase)
            PH_GROUP: begin
                if (hit) begin
                    n_last_hit = r_bin_counter;
                    n_gap      = '0;
                    if (i_mag > r_best_mag) begin
                        n_best_mag = i_mag;
                        n_best_bin = r_bin_counter;
                    end
                end else begin
                    n_gap = gap_inc;
                    if (gap_inc >= gap_lim) begin
                        closed  = 1'b1;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_phase = PH_SEARCH;
            end
            default: begin
                n_phase = PH_SEARCH;
                if (hit && (r_bin_counter >= i_cfg.start_bin)) begin
                    n_first    = r_bin_counter;
                    n_last_hit = r_bin_counter;
                    n_best_bin = r_bin_counter;
                    n_best_mag = i_mag;
                    n_gap      = '0;
                    n_phase    = PH_GROUP;
                end
            end
        endcase

        // result picks up the updated group record
        o_res.group_valid = closed || (n_phase == PH_GROUP);
        if (!end_bin) begin
            o_res.group_valid = 1'b1;
        end
        o_res.first_bin   = o_res.group_valid ? n_first    : '0;
        o_res.last_bin    = o_res.group_valid ? n_last_hit : '0;
        o_res.peak_bin    = o_res.group_valid ? n_best_bin : '0;
        o_res.peak_mag    = o_res.group_valid ? n_best_mag : '0;
        o_res.group_index = r_groups;
        o_res.frame_end   = end_bin;
        o_res_valid       = end_bin || closed;

        if (end_bin) begin
            n_bin_counter = '0;
            n_phase       = PH_SEARCH;
            n_gap         = '0;
            n_groups      = '0;
        end else begin
            if (closed && (r_groups != CNT_MAX)) begin
                n_groups = r_groups + CNT_W'(1);
            end
            n_bin_counter = r_bin_counter + BIN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_counter <= '0;
            r_phase       <= PH_SEARCH;
            r_first       <= '0;
            r_last_hit    <= '0;
            r_gap         <= '0;
            r_best_bin    <= '0;
            r_best_mag    <= '0;
            r_groups      <= '0;
        end else if (i_fire) begin
            r_bin_counter <= n_bin_counter;
            r_phase       <= n_phase;
            r_first       <= n_first;
            r_last_hit    <= n_last_hit;
            r_gap         <= n_gap;
            r_best_bin    <= n_best_bin;
            r_best_mag    <= n_best_mag;
            r_groups      <= n_groups;
        end
    end

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && end_bin |=> (r_bin_counter == '0) && (r_groups == '0)
                              && (r_phase == PH_SEARCH))
        else $error("frame end did not clear scan state");

    a_skip_one_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (r_phase == PH_SKIP) |=> (r_phase == PH_SEARCH))
        else $error("skip phase lasted more than one bin");

    a_close_to_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && closed && !end_bin |=> (r_phase == PH_SKIP))
        else $error("closed group not followed by skip");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_bin_counter) && $stable(r_phase) && $stable(r_groups))
        else $error("scan state moved without a request");

endmodule

// ----- sv/spectral_peak_group_detector.sv -----
// channel   dir  modport          payload
// i_bin     in   spgd_bin_if      bin_mag, frame_last
// o_grp     out  spgd_grp_if      group_valid, first_bin, last_bin, peak_bin,
//                                 peak_mag, group_index, frame_end
// i_cfg     in   spgd_cfg_if      index, data (0 threshold, 1 start_bin, 2 gap_limit)
//
// One bin per cycle sustained while results are not stalled at the output.
// Bin register feeds the compare/count scan logic, result lands in the output register.
// Config writes always accepted (ready tied high), applied the next cycle.
// Reset synchronous, active low; clears control state and config to defaults.
// A stalled result only holds back bins that would produce a result.
module spectral_peak_group_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spgd_bin_if.sink   i_bin,
    spgd_grp_if.source o_grp,
    spgd_cfg_if.sink   i_cfg
);
    import spgd_pkg::*;

    t_cfg    cfg;
    t_result scan_res;
    logic    scan_res_valid;

    logic             r_in_valid;
    logic [MAG_W-1:0] r_in_mag;
    logic             r_in_last;

    logic    r_out_valid;
    t_result r_out;

    logic out_free;
    logic scan_fire;

    assign out_free    = !r_out_valid || o_grp.ready;
    assign scan_fire   = r_in_valid && (!scan_res_valid || out_free);
    assign i_bin.ready = !r_in_valid || scan_fire;

    spgd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    spgd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (scan_fire),
        .i_mag       (r_in_mag),
        .i_last      (r_in_last),
        .o_res_valid (scan_res_valid),
        .o_res       (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_bin.ready) begin
            r_in_valid <= i_bin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bin.ready && i_bin.valid) begin
            r_in_mag  <= i_bin.bin_mag;
            r_in_last <= i_bin.frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= scan_fire && scan_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && scan_fire && scan_res_valid) begin
            r_out <= scan_res;
        end
    end

    assign o_grp.valid       = r_out_valid;
    assign o_grp.group_valid = r_out.group_valid;
    assign o_grp.first_bin   = r_out.first_bin;
    assign o_grp.last_bin    = r_out.last_bin;
    assign o_grp.peak_bin    = r_out.peak_bin;
    assign o_grp.peak_mag    = r_out.peak_mag;
    assign o_grp.group_index = r_out.group_index;
    assign o_grp.frame_end   = r_out.frame_end;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_grp.ready && scan_res_valid |-> !scan_fire)
        else $error("result register overwritten while stalled");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_fire && scan_res_valid |=> r_out_valid)
        else $error("scanned result not captured");

    a_bin_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !scan_res_valid |-> scan_fire)
        else $error("bin without result held back");

endmodule
